// ===== hw/rtl/sdssr_pkg.sv =====
// shared types, pin map, select codes and glyph table for the signed decimal segment decoder
`default_nettype none

package sdssr_pkg;

  localparam int unsigned AddrWidth  = 17;
  localparam int unsigned ValueWidth = 11;
  localparam int unsigned SelWidth   = 4;
  localparam int unsigned SegWidth   = 8;
  localparam int unsigned MagWidth   = 10;

  localparam int unsigned BlankPinLo = 10;
  localparam int unsigned BlankPinHi = 14;

  localparam int unsigned SelPinOnes = 11;
  localparam int unsigned SelPinTens = 9;
  localparam int unsigned SelPinHund = 8;
  localparam int unsigned SelPinSign = 13;

  localparam int unsigned ValPin8  = 12;
  localparam int unsigned ValPin9  = 15;
  localparam int unsigned ValPin10 = 16;

  localparam logic signed [ValueWidth-1:0] ValueMax = 11'sd999;
  localparam logic signed [ValueWidth-1:0] ValueMin = -11'sd999;

  localparam logic [SelWidth-1:0] SEL_SIGN = 4'b1000;
  localparam logic [SelWidth-1:0] SEL_HUND = 4'b0100;
  localparam logic [SelWidth-1:0] SEL_TENS = 4'b0010;
  localparam logic [SelWidth-1:0] SEL_ONES = 4'b0001;

  // active-high segment bits
  localparam logic [6:0] SEG_A = 7'h01;
  localparam logic [6:0] SEG_G = 7'h02;
  localparam logic [6:0] SEG_B = 7'h04;
  localparam logic [6:0] SEG_C = 7'h08;
  localparam logic [6:0] SEG_F = 7'h10;
  localparam logic [6:0] SEG_D = 7'h20;
  localparam logic [6:0] SEG_E = 7'h40;
  localparam logic [6:0] SEG_NONE = 7'h00;

  typedef struct packed {
    logic                         blank;
    logic [SelWidth-1:0]          sel;
    logic signed [ValueWidth-1:0] value;
  } addr_fields_t;

  function automatic logic [6:0] glyph(input logic [3:0] digit);
    logic [6:0] seg;
    unique case (digit)
      4'd0:    seg = SEG_A | SEG_B | SEG_C | SEG_D | SEG_E | SEG_F;
      4'd1:    seg = SEG_B | SEG_C;
      4'd2:    seg = SEG_A | SEG_B | SEG_G | SEG_D | SEG_E;
      4'd3:    seg = SEG_A | SEG_B | SEG_C | SEG_G | SEG_D;
      4'd4:    seg = SEG_F | SEG_G | SEG_B | SEG_C;
      4'd5:    seg = SEG_A | SEG_F | SEG_G | SEG_C | SEG_D;
      4'd6:    seg = SEG_A | SEG_C | SEG_D | SEG_E | SEG_F | SEG_G;
      4'd7:    seg = SEG_A | SEG_B | SEG_C;
      4'd8:    seg = SEG_A | SEG_B | SEG_C | SEG_D | SEG_E | SEG_F | SEG_G;
      4'd9:    seg = SEG_A | SEG_B | SEG_C | SEG_D | SEG_F | SEG_G;
      default: seg = SEG_NONE;
    endcase
    return seg;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/sdssr_unscramble.sv =====
// pulls the blanking pins, digit select and signed value out of the scrambled address
`default_nettype none

module sdssr_unscramble (
  input  wire logic [sdssr_pkg::AddrWidth-1:0] address,
  output sdssr_pkg::addr_fields_t              fields
);

  always_comb begin
    fields.blank = address[sdssr_pkg::BlankPinLo] | address[sdssr_pkg::BlankPinHi];
    fields.sel   = {address[sdssr_pkg::SelPinSign], address[sdssr_pkg::SelPinHund],
                    address[sdssr_pkg::SelPinTens], address[sdssr_pkg::SelPinOnes]};
    fields.value = {address[sdssr_pkg::ValPin10], address[sdssr_pkg::ValPin9],
                    address[sdssr_pkg::ValPin8], address[7:0]};
  end

endmodule

`default_nettype wire

// ===== hw/rtl/sdssr_digit.sv =====
// splits the magnitude into decimal digits and picks the segment byte for the selected digit
`default_nettype none

module sdssr_digit (
  input  wire sdssr_pkg::addr_fields_t         fields,
  output logic [sdssr_pkg::SegWidth-1:0]       segment_lines
);

  logic [sdssr_pkg::MagWidth-1:0] mag;
  logic [3:0]                     hund;
  logic [6:0]                     rem_hund;
  logic [3:0]                     tens;
  logic [3:0]                     ones;
  logic                           out_of_range;
  logic [6:0]                     lit;

  always_comb begin
    out_of_range = (fields.value > sdssr_pkg::ValueMax) || (fields.value < sdssr_pkg::ValueMin);
    mag = fields.value[sdssr_pkg::ValueWidth-1] ?
          sdssr_pkg::MagWidth'(-fields.value) : sdssr_pkg::MagWidth'(fields.value);

    hund = 4'd0;
    for (int k = 1; k <= 9; k++) begin
      if (mag >= sdssr_pkg::MagWidth'(k * 100)) hund = 4'(k);
    end
    rem_hund = 7'(mag - sdssr_pkg::MagWidth'(hund) * sdssr_pkg::MagWidth'(100));

    tens = 4'd0;
    for (int k = 1; k <= 9; k++) begin
      if (rem_hund >= 7'(k * 10)) tens = 4'(k);
    end
    ones = 4'(rem_hund - 7'(tens) * 7'd10);

    if (fields.blank) begin
      lit = sdssr_pkg::SEG_NONE;
    end else if (out_of_range) begin
      lit = sdssr_pkg::SEG_G;
    end else begin
      unique case (fields.sel)
        sdssr_pkg::SEL_SIGN: lit = fields.value[sdssr_pkg::ValueWidth-1] ?
                                   sdssr_pkg::SEG_G : sdssr_pkg::SEG_NONE;
        sdssr_pkg::SEL_HUND: lit = (mag < 10'd100) ? sdssr_pkg::SEG_NONE : sdssr_pkg::glyph(hund);
        sdssr_pkg::SEL_TENS: lit = (mag < 10'd10) ? sdssr_pkg::SEG_NONE : sdssr_pkg::glyph(tens);
        sdssr_pkg::SEL_ONES: lit = sdssr_pkg::glyph(ones);
        default:             lit = sdssr_pkg::SEG_NONE;
      endcase
    end

    // active low, point never lit
    segment_lines = ~{1'b0, lit};
  end

endmodule

`default_nettype wire

// ===== hw/rtl/signed_decimal_seven_segment_rom_core.sv =====
// Signed decimal seven-segment decoder: takes one 17-bit display ROM address per transfer and
// returns the active-low segment byte for the selected digit (sign, hundreds, tens or ones) of
// the signed value held on the scrambled address pins. One address is accepted every cycle while
// the input side is not stalled; each result passes through the input register and then the result
// register, with the single decode path between them. A stall on the result side
// holds the result register and, when both registers are full, stalls the input side.
`default_nettype none

module signed_decimal_seven_segment_rom_core (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire logic [sdssr_pkg::AddrWidth-1:0]      in_address,
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output logic [sdssr_pkg::SegWidth-1:0]            out_segment_lines
);

  logic                               s1_valid_r;
  logic                               s1_valid_nxt;
  logic [sdssr_pkg::AddrWidth-1:0]    s1_address_r;
  logic                               out_valid_r;
  logic                               out_valid_nxt;
  logic [sdssr_pkg::SegWidth-1:0]     out_segment_lines_r;
  logic                               out_load;
  logic                               in_take;
  sdssr_pkg::addr_fields_t            fields;
  logic [sdssr_pkg::SegWidth-1:0]     segment_lines;

  sdssr_unscramble u_unscramble (
    .address (s1_address_r),
    .fields  (fields)
  );

  sdssr_digit u_digit (
    .fields        (fields),
    .segment_lines (segment_lines)
  );

  always_comb begin
    out_load      = !out_valid_r || !out_stall;
    in_stall      = s1_valid_r && !out_load;
    in_take       = in_valid && !in_stall;
    s1_valid_nxt  = in_take || (s1_valid_r && !out_load);
    out_valid_nxt = out_load ? s1_valid_r : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_address_r <= in_address;
    end
    if (out_load && s1_valid_r) begin
      out_segment_lines_r <= segment_lines;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_segment_lines = out_segment_lines_r;

`ifndef NO_ASSERTIONS
  a_in_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r && out_stall))
    else $error("input stalled without a full pipe held by the result side");

  a_take_fills_s1: assert property (@(posedge clk) disable iff (!rst_n)
    in_take |=> s1_valid_r)
    else $error("accepted transfer lost before the input register");

  a_s1_moves_out: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_load) |=> out_valid_r)
    else $error("decoded item did not reach the result register");

  a_held_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> (out_valid_r && $stable(out_segment_lines_r)))
    else $error("stalled result register changed");
`endif

endmodule

`default_nettype wire

// ===== bench/tb_signed_decimal_seven_segment_rom_core.sv =====
// testbench for the signed decimal seven-segment decoder against a local decode
`timescale 1ns / 1ps

module tb_signed_decimal_seven_segment_rom_core;

  typedef struct {
    logic [sdssr_pkg::AddrWidth-1:0] address;
    logic [sdssr_pkg::SegWidth-1:0]  segments;
  } segment_entry_t;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_valid = 1'b0;
  logic                            in_stall;
  logic [sdssr_pkg::AddrWidth-1:0] in_address = '0;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  logic [sdssr_pkg::SegWidth-1:0]  out_segment_lines;

  segment_entry_t expected_segments[$];
  segment_entry_t want;
  int             errors = 0;
  int             stall_left = 0;
  int             hold_count = 0;
  int             hold_len = 0;
  bit             rx_quiet = 1'b0;
  bit             tx_quiet = 1'b0;

  signed_decimal_seven_segment_rom_core DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_address       (in_address),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_segment_lines(out_segment_lines)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic logic [6:0] digit_lit(input int d);
    logic [6:0] lit;
    case (d)
      0:       lit = 7'h7D;
      1:       lit = 7'h0C;
      2:       lit = 7'h67;
      3:       lit = 7'h2F;
      4:       lit = 7'h1E;
      5:       lit = 7'h3B;
      6:       lit = 7'h7B;
      7:       lit = 7'h0D;
      8:       lit = 7'h7F;
      default: lit = 7'h3F;
    endcase
    return lit;
  endfunction

  function automatic logic [sdssr_pkg::SegWidth-1:0] decode_segments(
      input logic [sdssr_pkg::AddrWidth-1:0] a);
    logic [sdssr_pkg::SelWidth-1:0]          sel;
    logic signed [sdssr_pkg::ValueWidth-1:0] v;
    int                                      mag;
    logic [6:0]                              lit;
    sel = {a[sdssr_pkg::SelPinSign], a[sdssr_pkg::SelPinHund],
           a[sdssr_pkg::SelPinTens], a[sdssr_pkg::SelPinOnes]};
    v   = {a[sdssr_pkg::ValPin10], a[sdssr_pkg::ValPin9], a[sdssr_pkg::ValPin8], a[7:0]};
    mag = (v < 0) ? -int'(v) : int'(v);
    if (a[sdssr_pkg::BlankPinLo] || a[sdssr_pkg::BlankPinHi]) begin
      lit = sdssr_pkg::SEG_NONE;
    end else if (mag > 999) begin
      lit = sdssr_pkg::SEG_G;
    end else begin
      case (sel)
        sdssr_pkg::SEL_SIGN: lit = (v < 0) ? sdssr_pkg::SEG_G : sdssr_pkg::SEG_NONE;
        sdssr_pkg::SEL_HUND: lit = (mag < 100) ? sdssr_pkg::SEG_NONE
                                               : digit_lit((mag / 100) % 10);
        sdssr_pkg::SEL_TENS: lit = (mag < 10) ? sdssr_pkg::SEG_NONE
                                              : digit_lit((mag % 100) / 10);
        sdssr_pkg::SEL_ONES: lit = digit_lit(mag % 10);
        default:             lit = sdssr_pkg::SEG_NONE;
      endcase
    end
    return {1'b1, ~lit};
  endfunction

  function automatic logic [sdssr_pkg::AddrWidth-1:0] make_address(
      input int value,
      input logic [sdssr_pkg::SelWidth-1:0] sel,
      input logic [1:0] blank);
    logic [sdssr_pkg::AddrWidth-1:0]  a;
    logic [sdssr_pkg::ValueWidth-1:0] v;
    v = value[sdssr_pkg::ValueWidth-1:0];
    a = '0;
    a[7:0]                   = v[7:0];
    a[sdssr_pkg::ValPin8]    = v[8];
    a[sdssr_pkg::ValPin9]    = v[9];
    a[sdssr_pkg::ValPin10]   = v[10];
    a[sdssr_pkg::SelPinOnes] = sel[0];
    a[sdssr_pkg::SelPinTens] = sel[1];
    a[sdssr_pkg::SelPinHund] = sel[2];
    a[sdssr_pkg::SelPinSign] = sel[3];
    a[sdssr_pkg::BlankPinLo] = blank[0];
    a[sdssr_pkg::BlankPinHi] = blank[1];
    return a;
  endfunction

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  function automatic logic [sdssr_pkg::SelWidth-1:0] one_hot_select();
    logic [sdssr_pkg::SelWidth-1:0] s;
    case ($urandom_range(0, 3))
      0:       s = sdssr_pkg::SEL_ONES;
      1:       s = sdssr_pkg::SEL_TENS;
      2:       s = sdssr_pkg::SEL_HUND;
      default: s = sdssr_pkg::SEL_SIGN;
    endcase
    return s;
  endfunction

  function automatic logic [sdssr_pkg::AddrWidth-1:0] random_address();
    int r;
    int mag;
    int value;
    r = $urandom_range(0, 99);
    case ($urandom_range(0, 3))
      0:       mag = $urandom_range(0, 9);
      1:       mag = $urandom_range(10, 99);
      2:       mag = $urandom_range(100, 999);
      default: mag = $urandom_range(0, 999);
    endcase
    value = $urandom_range(0, 1) ? -mag : mag;
    if (r < 70) return make_address(value, one_hot_select(), 2'b00);
    if (r < 80) begin
      value = $urandom_range(0, 1) ? -int'($urandom_range(1000, 1024))
                                   : int'($urandom_range(1000, 1023));
      return make_address(value, 4'($urandom_range(0, 15)), 2'b00);
    end
    if (r < 88) return make_address(value, 4'($urandom_range(0, 15)), 2'b00);
    if (r < 94) return make_address(value, one_hot_select(), 2'($urandom_range(1, 3)));
    return sdssr_pkg::AddrWidth'($urandom_range(0, (1 << sdssr_pkg::AddrWidth) - 1));
  endfunction

  // result side backpressure
  always @(posedge clk) begin
    if (hold_len != 0) begin
      hold_count = hold_len;
      hold_len   = 0;
    end
    if (hold_count > 0) begin
      hold_count--;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (!rx_quiet && $urandom_range(0, 99) < 30) begin
      stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(3, 23) : $urandom_range(0, 2);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_segments.size() == 0) begin
        $display("%0t: result transfer with nothing expected, actual %h",
                 $time, out_segment_lines);
        errors++;
      end else begin
        want = expected_segments.pop_front();
        if (out_segment_lines !== want.segments) begin
          $display("%0t: address %h expected %h actual %h",
                   $time, want.address, want.segments, out_segment_lines);
          errors++;
        end
      end
    end
  end

  task automatic send_address(input logic [sdssr_pkg::AddrWidth-1:0] a, input int gap);
    in_valid   <= 1'b1;
    in_address <= a;
    do @(posedge clk); while (in_stall);
    expected_segments.push_back('{address: a, segments: decode_segments(a)});
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic test_digits();
    send_address(make_address(999, sdssr_pkg::SEL_ONES, 2'b00), idle_len());
    send_address(make_address(999, sdssr_pkg::SEL_TENS, 2'b00), idle_len());
    send_address(make_address(999, sdssr_pkg::SEL_HUND, 2'b00), idle_len());
    send_address(make_address(-999, sdssr_pkg::SEL_SIGN, 2'b00), idle_len());
    send_address(make_address(0, sdssr_pkg::SEL_ONES, 2'b00), idle_len());
    send_address(make_address(0, sdssr_pkg::SEL_TENS, 2'b00), idle_len());
    send_address(make_address(0, sdssr_pkg::SEL_HUND, 2'b00), idle_len());
    send_address(make_address(0, sdssr_pkg::SEL_SIGN, 2'b00), idle_len());
    send_address(make_address(-7, sdssr_pkg::SEL_TENS, 2'b00), idle_len());
    send_address(make_address(-7, sdssr_pkg::SEL_SIGN, 2'b00), idle_len());
    send_address(make_address(42, sdssr_pkg::SEL_HUND, 2'b00), idle_len());
    send_address(make_address(-305, sdssr_pkg::SEL_TENS, 2'b00), idle_len());
  endtask

  task automatic test_out_of_range();
    send_address(make_address(1000, sdssr_pkg::SEL_ONES, 2'b00), idle_len());
    send_address(make_address(-1000, sdssr_pkg::SEL_SIGN, 2'b00), idle_len());
    send_address(make_address(1023, 4'b0000, 2'b00), idle_len());
    send_address(make_address(-1024, 4'b1111, 2'b00), idle_len());
  endtask

  task automatic test_bad_select();
    send_address(make_address(123, 4'b0000, 2'b00), idle_len());
    send_address(make_address(-123, 4'b0011, 2'b00), idle_len());
    send_address(make_address(123, 4'b1111, 2'b00), idle_len());
  endtask

  task automatic test_blanking();
    send_address(make_address(5, sdssr_pkg::SEL_ONES, 2'b01), idle_len());
    send_address(make_address(1023, sdssr_pkg::SEL_ONES, 2'b10), idle_len());
    send_address(make_address(-1024, 4'b1111, 2'b11), idle_len());
  endtask

  task automatic test_long_hold();
    int n;
    hold_len = 100;
    for (n = 0; n < 40; n++) begin
      send_address(random_address(), 0);
    end
  endtask

  task automatic test_random_traffic(input int count);
    int n;
    for (n = 0; n < count; n++) begin
      if (n % 60 == 0) begin
        tx_quiet = ($urandom_range(0, 3) == 0);
        rx_quiet = ($urandom_range(0, 3) == 0);
      end
      send_address(random_address(), tx_quiet ? 0 : idle_len());
    end
    rx_quiet = 1'b0;
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    test_digits();
    test_out_of_range();
    test_bad_select();
    test_blanking();
    test_long_hold();
    test_random_traffic(1600);
    in_valid <= 1'b0;
    while (expected_segments.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/sdssr_pkg.sv
hw/rtl/sdssr_unscramble.sv
hw/rtl/sdssr_digit.sv
hw/rtl/signed_decimal_seven_segment_rom_core.sv
bench/tb_signed_decimal_seven_segment_rom_core.sv
